### hdl/kmss_pkg.sv
package kmss_pkg;

    // opcode field of an input transfer
    localparam logic [1:0] OP_PATTERN = 2'd0;
    localparam logic [1:0] OP_TEXT    = 2'd1;
    localparam logic [1:0] OP_END     = 2'd2;

    // register index (paddr[2])
    localparam logic REG_MAX_MISMATCHES = 1'b0;

    // mismatch counters saturate at their all-ones value
    localparam int             CNT_W   = 7;
    localparam logic [CNT_W-1:0] CNT_SAT = '1;

    localparam int MS_W = 16;

    // controls from the search sequencer to the alignment array
    typedef struct packed {
        logic       load;   // shift a pattern byte in
        logic       clear;  // zero all alignment counters
        logic       step;   // advance all alignments by one text byte
        logic [7:0] data;
    } t_arr_ctl;

    // one result transfer
    typedef struct packed {
        logic            found;
        logic [MS_W-1:0] match_start;
        logic            error;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a, input logic inc);
        logic [CNT_W-1:0] r;
        r = a;
        if (inc && (a != CNT_SAT)) begin
            r = a + CNT_W'(1);
        end
        return r;
    endfunction

endpackage

### hdl/k_mismatch_substring_search_core.sv
// Channel   | Transfer               | tdata          | tuser (low bit up)
// ----------+------------------------+----------------+------------------------------
// s_axis    | command / byte in      | data_byte      | opcode[1:0], first_of_pattern
// m_axis    | search result out      | match_start    | found, error
// APB       | register write / read  | max_mismatches at address 0
//
// One input transfer per cycle while s_axis_tready is high; every alignment
// counter updates in parallel in the counter row.
// A result is registered and offered the cycle after its input, or later from skid.
// Synchronous reset clears all counters at once; no clearing pass.
// A two-entry output (register plus skid) absorbs one stall; s_axis_tready
// drops only while the skid entry is occupied.
module k_mismatch_substring_search_core #(
    parameter int              PAT_MAX  = 64,
    parameter longint unsigned TEXT_MAX = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [2:0]  s_axis_tuser,   // opcode[1:0], first_of_pattern[2]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // match_start
    output logic [1:0]  m_axis_tuser,   // found[0], error[1]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kmss_pkg::*;

    localparam int LEN_W = $clog2(PAT_MAX + 1);
    localparam int POS_W = $clog2(TEXT_MAX + 1);
    localparam int CMP_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
    localparam int EXT_W = (POS_W > MS_W) ? POS_W : MS_W;

    // search state
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_pat_ovf, n_pat_ovf;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_reported, n_reported;
    logic             r_text_ovf, n_text_ovf;
    logic [CNT_W-1:0] r_max;

    // output register and skid entry
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    t_arr_ctl         w_ctl;
    logic [CNT_W-1:0] w_total;
    logic             w_accept;
    logic [1:0]       w_op;
    logic             w_first;
    logic [LEN_W-1:0] w_base_len;
    logic             w_done;
    logic [EXT_W-1:0] w_pos_ext;
    logic [MS_W-1:0]  w_start;
    logic             w_emit;
    t_result          w_res;
    logic             w_take;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_op     = s_axis_tuser[1:0];
    assign w_first  = s_axis_tuser[2];

    kmss_align_array #(
        .PAT_MAX (PAT_MAX),
        .LEN_W   (LEN_W)
    ) u_array (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_len   (r_len),
        .o_total (w_total)
    );

    // alignment completes once position+1 reaches the pattern length
    assign w_done    = (CMP_W'(r_pos) + CMP_W'(1)) >= CMP_W'(r_len);
    assign w_pos_ext = EXT_W'(r_pos);
    assign w_start   = w_pos_ext[MS_W-1:0] + MS_W'(1) - MS_W'(r_len);
    assign w_base_len = w_first ? '0 : r_len;

    // search sequencing for one accepted transfer
    always_comb begin
        n_len      = r_len;
        n_pat_ovf  = r_pat_ovf;
        n_pos      = r_pos;
        n_reported = r_reported;
        n_text_ovf = r_text_ovf;
        w_ctl      = '{load: 1'b0, clear: 1'b0, step: 1'b0, data: s_axis_tdata};
        w_emit     = 1'b0;
        w_res      = '{found: 1'b0, match_start: '0, error: 1'b0};

        if (w_accept) begin
            case (w_op)
                OP_PATTERN: begin
                    n_pat_ovf = w_first ? 1'b0 : r_pat_ovf;
                    if (w_base_len < LEN_W'(PAT_MAX)) begin
                        w_ctl.load = 1'b1;
                        n_len      = w_base_len + LEN_W'(1);
                    end else begin
                        n_len     = w_base_len;
                        n_pat_ovf = 1'b1;
                    end
                    w_ctl.clear = 1'b1;
                    n_pos       = '0;
                    n_reported  = 1'b0;
                    n_text_ovf  = 1'b0;
                end
                OP_TEXT: begin
                    if (!r_reported) begin
                        if (r_pat_ovf) begin
                            w_emit    = 1'b1;
                            w_res.error = 1'b1;
                        end else if (r_len == '0) begin
                            w_emit    = 1'b1;
                            w_res.found = 1'b1;
                        end else if (r_pos >= POS_W'(TEXT_MAX)) begin
                            n_text_ovf  = 1'b1;
                            w_emit      = 1'b1;
                            w_res.error = 1'b1;
                        end else begin
                            w_ctl.step = 1'b1;
                            n_pos      = r_pos + POS_W'(1);
                            if (w_done && (w_total <= r_max)) begin
                                w_emit            = 1'b1;
                                w_res.found       = 1'b1;
                                w_res.match_start = w_start;
                            end
                        end
                        if (w_emit) begin
                            n_reported = 1'b1;
                        end
                    end
                end
                OP_END: begin
                    if (!r_reported) begin
                        w_emit = 1'b1;
                        if (r_pat_ovf) begin
                            w_res.error = 1'b1;
                        end else if (r_len == '0) begin
                            w_res.found = 1'b1;
                        end else begin
                            w_res.error = r_text_ovf;
                        end
                    end
                    w_ctl.clear = 1'b1;
                    n_pos       = '0;
                    n_reported  = 1'b0;
                    n_text_ovf  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // output register with one skid entry
    assign w_take = r_out_valid && m_axis_tready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (w_emit) begin
            if (!r_out_valid || w_take) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_res;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_pat_ovf    <= 1'b0;
            r_pos        <= '0;
            r_reported   <= 1'b0;
            r_text_ovf   <= 1'b0;
            r_max        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_len        <= n_len;
            r_pat_ovf    <= n_pat_ovf;
            r_pos        <= n_pos;
            r_reported   <= n_reported;
            r_text_ovf   <= n_text_ovf;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_MISMATCHES)) begin
                r_max <= pwdata[CNT_W-1:0];
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // register reads
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_MISMATCHES) ? 32'(r_max) : '0;

    assign s_axis_tready   = !r_skid_valid;
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out.match_start;
    assign m_axis_tuser[0] = r_out.found;
    assign m_axis_tuser[1] = r_out.error;

endmodule

### hdl/kmss_align_array.sv
// Pattern shift register and one mismatch counter per open alignment.
// Pattern is held reversed: r_pat[0] is the last pattern byte.
// Cell j holds the alignment that still needs j+1 bytes, so the
// alignment that completes on this byte is always cell 0.
module kmss_align_array #(
    parameter int PAT_MAX = 64,
    parameter int LEN_W   = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kmss_pkg::t_arr_ctl        i_ctl,
    input  logic [LEN_W-1:0]          i_len,
    output logic [kmss_pkg::CNT_W-1:0] o_total
);
    import kmss_pkg::*;

    logic [7:0]       r_pat [PAT_MAX];
    logic [CNT_W-1:0] r_cnt [PAT_MAX];
    logic [CNT_W-1:0] n_cnt [PAT_MAX];

    // pattern byte shifts in at the low end
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pat[0] <= i_ctl.data;
            for (int j = 1; j < PAT_MAX; j++) begin
                r_pat[j] <= r_pat[j-1];
            end
        end
    end

    // row of counter cells, each but the top fed by its upper neighbor
    for (genvar j = 0; j < PAT_MAX; j++) begin : g_cell
        if (j < PAT_MAX - 1) begin : g_mid
            always_comb begin
                n_cnt[j] = r_cnt[j];
                if (i_ctl.clear) begin
                    n_cnt[j] = '0;
                end else if (i_ctl.step) begin
                    if (LEN_W'(j + 1) < i_len) begin
                        n_cnt[j] = sat_inc(r_cnt[j+1], i_ctl.data != r_pat[j+1]);
                    end else begin
                        // new alignment enters at cell len-1
                        n_cnt[j] = '0;
                    end
                end
            end
        end else begin : g_top
            always_comb begin
                n_cnt[j] = r_cnt[j];
                if (i_ctl.clear || i_ctl.step) begin
                    n_cnt[j] = '0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt[j] <= '0;
            end else begin
                r_cnt[j] <= n_cnt[j];
            end
        end
    end

    // total of the alignment that completes on the current byte
    assign o_total = sat_inc(r_cnt[0], i_ctl.data != r_pat[0]);

endmodule

### sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kmss_pkg::*;

    // opcode the block ignores
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    // register index with nothing behind it
    localparam logic       REG_UNUSED = 1'b1;
    localparam int         PAT_MAX    = 64;
    localparam int         TEXT_LIMIT = 65536;
    // cycles to let pass once the last report is in
    localparam int         SETTLE_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // data_byte
    logic [2:0]  s_axis_tuser = '0;   // opcode[1:0], first_of_pattern
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // match_start
    logic [1:0]  m_axis_tuser;        // found, error
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    k_mismatch_substring_search_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // search state as the block should hold it
    logic [7:0]       pat_mem   [PAT_MAX] = '{default: '0};
    logic [CNT_W-1:0] align_cnt [PAT_MAX] = '{default: '0};
    int               pat_len   = 0;
    bit               pat_ovf   = 1'b0;
    int               text_pos  = 0;
    bit               reported  = 1'b0;
    bit               text_ovf  = 1'b0;
    logic [CNT_W-1:0] mm_limit  = '0;

    t_result expected_reports [$];
    int      fail_count    = 0;
    int      items_sent    = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c, input logic miss);
        return (miss && c != {CNT_W{1'b1}}) ? c + 1'b1 : c;
    endfunction

    function automatic void restart_search();
        align_cnt = '{default: '0};
        text_pos  = 0;
        reported  = 1'b0;
        text_ovf  = 1'b0;
    endfunction

    function automatic void expect_report(input logic f, input logic [15:0] s, input logic e);
        t_result r;
        r.found       = f;
        r.match_start = s;
        r.error       = e;
        expected_reports = {expected_reports, r};
        reported = 1'b1;
    endfunction

    // advance the search state by one accepted transfer
    function automatic void predict_search(input logic [1:0] op, input logic [7:0] val,
                                           input logic first);
        logic [CNT_W-1:0] total;
        bit               complete;
        case (op)
            OP_PATTERN: begin
                if (first) begin
                    pat_len = 0;
                    pat_ovf = 1'b0;
                end
                if (pat_len < PAT_MAX) begin
                    pat_mem[pat_len] = val;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
                restart_search();
            end
            OP_TEXT: begin
                if (reported) begin
                    // nothing until end of text
                end else if (pat_ovf) begin
                    expect_report(1'b0, '0, 1'b1);
                end else if (pat_len == 0) begin
                    expect_report(1'b1, '0, 1'b0);
                end else if (text_pos >= TEXT_LIMIT) begin
                    text_ovf = 1'b1;
                    expect_report(1'b0, '0, 1'b1);
                end else begin
                    total    = bump(align_cnt[pat_len-1], val != pat_mem[pat_len-1]);
                    complete = (text_pos + 1 >= pat_len);
                    for (int i = pat_len - 1; i >= 1; i--) begin
                        align_cnt[i] = bump(align_cnt[i-1], val != pat_mem[i-1]);
                    end
                    align_cnt[0] = '0;
                    text_pos++;
                    if (complete && total <= mm_limit) begin
                        expect_report(1'b1, 16'(text_pos - pat_len), 1'b0);
                    end
                end
            end
            OP_END: begin
                if (!reported) begin
                    if (pat_ovf) begin
                        expect_report(1'b0, '0, 1'b1);
                    end else if (pat_len == 0) begin
                        expect_report(1'b1, '0, 1'b0);
                    end else begin
                        expect_report(1'b0, '0, text_ovf);
                    end
                end
                restart_search();
            end
            default: begin
                // ignored opcode
            end
        endcase
    endfunction

    function automatic void note_field(input string what, input longint want, input longint got);
        fail_count++;
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endfunction

    // receiver: random stalls, compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_reports.size() == 0) begin
                note_field("unexpected report, match_start", -1, longint'(m_axis_tdata));
            end else begin
                want = expected_reports.pop_front();
                if (m_axis_tuser[0] != want.found) begin
                    note_field("found", longint'(want.found), longint'(m_axis_tuser[0]));
                end
                if (m_axis_tdata != want.match_start) begin
                    note_field("match_start", longint'(want.match_start),
                               longint'(m_axis_tdata));
                end
                if (m_axis_tuser[1] != want.error) begin
                    note_field("error", longint'(want.error), longint'(m_axis_tuser[1]));
                end
            end
        end
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic push_cmd(input logic [1:0] op, input logic [7:0] val, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= {first, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_search(op, val, first);
        if (op != OP_UNUSED) items_sent++;
    endtask

    // stop sending and wait until every expected report is in
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write then read back, done while the block is idle
    task automatic set_limit(input logic idx, input logic [31:0] value);
        logic [31:0] got;
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_MAX_MISMATCHES) mm_limit = value[CNT_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_MAX_MISMATCHES && got != 32'(mm_limit)) begin
            note_field("max_mismatches readback", longint'(mm_limit), longint'(got));
        end
    endtask

    task automatic test_directed_cases();
        // empty pattern after reset: end of text and text byte both match at 0
        push_cmd(OP_END, 8'hFF, 1'b1);
        push_cmd(OP_TEXT, 8'h00, 1'b0);
        push_cmd(OP_TEXT, 8'hFF, 1'b1);
        push_cmd(OP_END, 8'h00, 1'b0);
        push_cmd(OP_UNUSED, 8'hFF, 1'b1);
        // exact match at offset 1
        push_cmd(OP_PATTERN, 8'h00, 1'b1);
        push_cmd(OP_PATTERN, 8'hFF, 1'b0);
        push_cmd(OP_TEXT, 8'hFF, 1'b0);
        push_cmd(OP_TEXT, 8'h00, 1'b0);
        push_cmd(OP_TEXT, 8'hFF, 1'b0);
        push_cmd(OP_END, 8'h00, 1'b1);
        // no match before end of text
        push_cmd(OP_PATTERN, 8'h00, 1'b1);
        push_cmd(OP_TEXT, 8'hFF, 1'b0);
        push_cmd(OP_TEXT, 8'hFF, 1'b0);
        push_cmd(OP_END, 8'hFF, 1'b0);
        // limit above 64 accepts any alignment
        set_limit(REG_MAX_MISMATCHES, 32'hFFFF_FF7F);
        push_cmd(OP_PATTERN, 8'hAA, 1'b1);
        push_cmd(OP_PATTERN, 8'hBB, 1'b0);
        push_cmd(OP_PATTERN, 8'hCC, 1'b0);
        push_cmd(OP_TEXT, 8'h00, 1'b0);
        push_cmd(OP_TEXT, 8'h00, 1'b0);
        push_cmd(OP_TEXT, 8'h00, 1'b0);
        push_cmd(OP_END, 8'h00, 1'b0);
        // a write to an empty address must leave the limit alone
        set_limit(REG_UNUSED, 32'h0000_0000);
        push_cmd(OP_PATTERN, 8'h01, 1'b1);
        push_cmd(OP_TEXT, 8'h02, 1'b0);
        push_cmd(OP_END, 8'h00, 1'b0);
    endtask

    task automatic test_pattern_limits();
        // full-length pattern: all bytes mismatched at limit 64, one matched at limit 63
        set_limit(REG_MAX_MISMATCHES, 32'd64);
        for (int k = 0; k < PAT_MAX; k++) push_cmd(OP_PATTERN, 8'h00, k == 0);
        for (int k = 0; k < PAT_MAX; k++) push_cmd(OP_TEXT, 8'hFF, 1'b0);
        push_cmd(OP_END, 8'h00, 1'b0);
        set_limit(REG_MAX_MISMATCHES, 32'd63);
        for (int k = 0; k < PAT_MAX - 1; k++) push_cmd(OP_TEXT, 8'hFF, 1'b0);
        push_cmd(OP_TEXT, 8'h00, 1'b0);
        push_cmd(OP_TEXT, 8'h00, 1'b0);
        push_cmd(OP_END, 8'h00, 1'b0);
        // pattern one byte too long: error on text, then on a bare end of text
        for (int k = 0; k <= PAT_MAX; k++) push_cmd(OP_PATTERN, 8'(k), k == 0);
        push_cmd(OP_TEXT, 8'h00, 1'b0);
        push_cmd(OP_TEXT, 8'h01, 1'b0);
        push_cmd(OP_END, 8'h00, 1'b0);
        push_cmd(OP_END, 8'h00, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int               stop_at;
        int               searches;
        int               r;
        int               plen;
        int               tlen;
        int               at;
        bit               narrow;
        logic [7:0]       b;
        logic [7:0]       pat [$];
        logic [7:0]       txt [$];
        logic [CNT_W-1:0] lim;
        stop_at  = items_sent + n_items;
        searches = 0;
        while (items_sent < stop_at) begin
            // new limit every few searches, extremes included
            if (searches % 5 == 4) begin
                case ($urandom_range(5))
                    0: lim = 7'd0;
                    1: lim = 7'd1;
                    2: lim = 7'd2;
                    3: lim = 7'd64;
                    4: lim = 7'd127;
                    default: lim = CNT_W'($urandom_range(127));
                endcase
                set_limit(REG_MAX_MISMATCHES, ($urandom() & ~32'h7F) | 32'(lim));
            end
            narrow = 1'($urandom_range(1));
            r = $urandom_range(99);
            if (r < 65)      plen = $urandom_range(1, 6);
            else if (r < 88) plen = $urandom_range(7, 16);
            else if (r < 96) plen = $urandom_range(17, PAT_MAX);
            else             plen = $urandom_range(PAT_MAX + 1, PAT_MAX + 4);
            // pattern; now and then appended to the old one instead of replacing it
            pat.delete();
            for (int k = 0; k < plen; k++) begin
                b = narrow ? 8'h61 + 8'($urandom_range(1)) : 8'($urandom_range(255));
                pat = {pat, b};
                push_cmd(OP_PATTERN, b,
                         (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0));
            end
            // text, often with a lightly damaged copy of the pattern planted in it
            tlen = $urandom_range(0, 40);
            txt.delete();
            for (int k = 0; k < tlen; k++) begin
                b = narrow ? 8'h61 + 8'($urandom_range(1)) : 8'($urandom_range(255));
                txt = {txt, b};
            end
            if (plen <= tlen && $urandom_range(99) < 60) begin
                at = $urandom_range(0, tlen - plen);
                for (int j = 0; j < plen; j++) begin
                    txt[at+j] = ($urandom_range(99) < 10) ? 8'($urandom_range(255)) : pat[j];
                end
            end
            for (int k = 0; k < tlen; k++) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    push_cmd(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
                end else if (r < 5) begin
                    push_cmd(OP_PATTERN, 8'($urandom_range(255)), 1'b0);
                end
                push_cmd(OP_TEXT, txt[k], 1'($urandom_range(1)));
            end
            if ($urandom_range(9) != 0) begin
                push_cmd(OP_END, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            searches++;
        end
    endtask

    initial begin
        send_idle_pct = 20;
        recv_idle_pct = 51;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_pattern_limits();
        test_random_traffic(170);
        drain_results();
        send_idle_pct = 51;
        recv_idle_pct = 20;
        test_random_traffic(170);
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(170);
        drain_results();
        if (fail_count == 0) begin
            $display("k_mismatch_substring_search_core: match");
        end else begin
            $display("k_mismatch_substring_search_core: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10ms;
        $display("k_mismatch_substring_search_core: mismatch");
        $finish;
    end

endmodule
